// ----- sv/sqmm_pkg.sv -----
// Shared types and constants for the square matrix multiply core.
package sqmm_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;
    localparam int DIM_W  = 7;
    localparam int MODE_W = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    localparam logic [MODE_W-1:0] MODE_WR_LEFT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_RIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRODUCT  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] element;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
        logic signed [DATA_W-1:0] product_value;
    } out_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             write_left;
        logic             write_right;
        logic             load;
        logic             issue;
        logic [DIM_W-1:0] k;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic             req_ok;
        logic [DIM_W-1:0] eff_dim;
    } dp_status_t;

endpackage

// ----- sv/sqmm_ram.sv -----
// Generic simple dual-port RAM with registered read.
module sqmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/sqmm_ctrl.sv -----
// Controller state machine sequencing writes and dot-product requests.
module sqmm_ctrl
    import sqmm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [MODE_W-1:0] mode,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       result_valid
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Last drain step; the accumulator is final when the controller leaves it
    localparam logic [1:0] DRAIN_LAST = 2'd1;

    logic [1:0]       state_reg, state_next;
    logic [DIM_W-1:0] k_reg, k_next;
    logic [1:0]       drain_reg, drain_next;
    logic             accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        drain_next      = drain_reg;
        cmd.write_left  = 1'b0;
        cmd.write_right = 1'b0;
        cmd.load        = 1'b0;
        cmd.issue       = 1'b0;
        cmd.k           = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.write_left  = (mode == MODE_WR_LEFT);
                    cmd.write_right = (mode == MODE_WR_RIGHT);
                    if (mode == MODE_PRODUCT)
                    begin
                        cmd.load = 1'b1;
                        k_next   = '0;
                        // empty or out-of-range request: report zero at once
                        state_next = status.req_ok ? ST_RUN : ST_DONE;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (k_reg == status.eff_dim - DIM_W'(1))
                begin
                    state_next = ST_DRAIN;
                    drain_next = '0;
                end
                else
                begin
                    k_next = k_reg + DIM_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == DRAIN_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    drain_next = drain_reg + 2'd1;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            drain_reg <= drain_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_DONE);

endmodule

// ----- sv/sqmm_datapath.sv -----
// Datapath: matrix stores, multiply-accumulate and dimension register.
module sqmm_datapath
    import sqmm_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  in_item_t         item,
    input  ctrl_cmd_t        cmd,
    input  logic             cfg_we,
    input  logic [DIM_W-1:0] cfg_data,
    output dp_status_t       status,
    output out_item_t        result
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DIM_W-1:0]  dim_reg;
    logic [DIM_W-1:0]  eff_dim;
    logic [IDX_W-1:0]  row_reg, col_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] prod_reg;
    logic              rd_valid_reg, prod_valid_reg;

    logic              wr_in_range;
    logic [AW-1:0]     waddr, left_raddr, right_raddr;
    logic [DATA_W-1:0] left_rdata, right_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            dim_reg <= cfg_data;
        end
    end

    // Saturate the dimension at the store size
    assign eff_dim = (32'(dim_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : dim_reg;

    assign status.eff_dim = eff_dim;
    assign status.req_ok  = (eff_dim != '0)
                         && ({1'b0, item.row} < eff_dim)
                         && ({1'b0, item.col} < eff_dim);

    assign wr_in_range = (32'(item.row) < MAX_DIM) && (32'(item.col) < MAX_DIM);
    assign waddr       = AW'(32'(item.row) * MAX_DIM + 32'(item.col));
    assign left_raddr  = AW'(32'(row_reg) * MAX_DIM + 32'(cmd.k));
    assign right_raddr = AW'(32'(cmd.k) * MAX_DIM + 32'(col_reg));

    sqmm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_left_ram (
        .clk   (clk),
        .we    (cmd.write_left && wr_in_range),
        .waddr (waddr),
        .wdata (item.element),
        .re    (cmd.issue),
        .raddr (left_raddr),
        .rdata (left_rdata)
    );

    sqmm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_right_ram (
        .clk   (clk),
        .we    (cmd.write_right && wr_in_range),
        .waddr (waddr),
        .wdata (item.element),
        .re    (cmd.issue),
        .raddr (right_raddr),
        .rdata (right_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.issue;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    // Low half of the product is the same for signed and unsigned operands
    always_ff @(posedge clk)
    begin
        prod_reg <= left_rdata * right_rdata;
        if (cmd.load)
        begin
            row_reg <= item.row;
            col_reg <= item.col;
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign result.out_row       = row_reg;
    assign result.out_col       = col_reg;
    assign result.product_value = acc_reg;

endmodule

// ----- sv/square_matrix_multiply_core.sv -----
// Top level of the square matrix multiply core.
//
// Holds two square matrices of signed 32-bit words, up to MAX_DIM by MAX_DIM.
// An item on the request port is taken at a rising edge with start high and
// busy low. Mode left/right write stores item.element at (row, col);
// indices at or beyond MAX_DIM are dropped. Mode product returns the
// dot product of that row of the left matrix with that column of the right
// matrix over the configured dimension, wrapped to 32 bits.
// A product transaction walks one element pair per cycle through a shared
// multiply-accumulate fed by one read port on each matrix RAM, for n pairs
// (n the dimension, capped at MAX_DIM). Busy stays high until the result
// strobe cycle ends, so a new request is taken only after that result is out.
// Out-of-range or empty requests return zero on the cycle after acceptance.
// Writes leave busy low.
// The result holds for exactly one cycle under result_valid; the receiver
// cannot stall it. The dimension register is written over the cfg channel,
// which is always ready; write it only while busy is low.
// Reset clears the controller and sets the dimension to 64; matrix contents
// are undefined until written.
module square_matrix_multiply_core
    import sqmm_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_item_t         item,
    output logic             result_valid,
    output out_item_t        result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [DIM_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    sqmm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .mode         (item.mode),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    sqmm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cmd      (cmd),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .status   (status),
        .result   (result)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the square matrix multiply core.
`timescale 1ns / 100ps

module testbench
    import sqmm_pkg::*;
();

    localparam int MATRIX_DIM    = 64;
    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 80;
    localparam int RUN_LIMIT     = 1000000;
    localparam int NUM_PHASES    = 12;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] ELEM_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] ELEM_MAX = 32'sh7FFF_FFFF;

    // Dimension and item count of each random phase; sender idling per third
    localparam int PHASE_DIM [NUM_PHASES]   = '{1, 3, 127, 5, 2, 8, 0, 4, 16, 6, 64, 7};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{60, 90, 150, 90, 60, 120, 40, 80, 120, 80,
                                                150, 80};
    localparam int PHASE_IDLE [3]           = '{20, 82, 0};

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    in_item_t         item = '0;
    logic             result_valid;
    out_item_t        result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [DIM_W-1:0] cfg_data = '0;

    in_item_t         pending_items[$];
    out_item_t        expected_products[$];
    logic [DATA_W-1:0] lhs_mem [MATRIX_DIM*MATRIX_DIM];
    logic [DATA_W-1:0] rhs_mem [MATRIX_DIM*MATRIX_DIM];
    logic [DIM_W-1:0] active_dim = DIM_RESET;
    bit               lhs_set [MATRIX_DIM*MATRIX_DIM];
    bit               rhs_set [MATRIX_DIM*MATRIX_DIM];
    int               idle_pct = 20;
    int               error_count = 0;
    int               cycle_count = 0;

    square_matrix_multiply_core #(
        .MAX_DIM (MATRIX_DIM)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic out_item_t dot_product_of(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
        out_item_t        res;
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] term;
        int               n;
        n = (active_dim > MATRIX_DIM) ? MATRIX_DIM : int'(active_dim);
        acc = '0;
        if (r < n && c < n)
        begin
            for (int k = 0; k < n; k++)
            begin
                term = lhs_mem[r*MATRIX_DIM + k] * rhs_mem[k*MATRIX_DIM + c];
                acc = acc + term;
            end
        end
        res.out_row = r;
        res.out_col = c;
        res.product_value = acc;
        return res;
    endfunction

    // Driver: present queued items, update the matrix mirror on each accepted write and queue the expected product
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                case (item.mode)
                    MODE_WR_LEFT:  lhs_mem[{item.row, item.col}] = item.element;
                    MODE_WR_RIGHT: rhs_mem[{item.row, item.col}] = item.element;
                    MODE_PRODUCT:  expected_products.push_back(dot_product_of(item.row, item.col));
                    default: ;
                endcase
                void'(pending_items.pop_front());
            end
            if (!start || !busy)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    start <= 1'b1;
                    item  <= pending_items[0];
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result against the oldest expected product
    always @(posedge clk)
    begin
        out_item_t want;
        if (result_valid)
        begin
            if (expected_products.size() == 0)
            begin
                $error("unexpected result: row %0d col %0d value %0d",
                       result.out_row, result.out_col, result.product_value);
                error_count++;
            end
            else
            begin
                want = expected_products.pop_front();
                if (result.out_row !== want.out_row)
                begin
                    $error("out_row mismatch: expected %0d, actual %0d",
                           want.out_row, result.out_row);
                    error_count++;
                end
                if (result.out_col !== want.out_col)
                begin
                    $error("out_col mismatch: expected %0d, actual %0d",
                           want.out_col, result.out_col);
                    error_count++;
                end
                if (result.product_value !== want.product_value)
                begin
                    $error("product_value mismatch: expected %0d, actual %0d",
                           want.product_value, result.product_value);
                    error_count++;
                end
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_element();
        case ($urandom_range(9))
            0:       return ELEM_MIN;
            1:       return ELEM_MAX;
            2:       return -1;
            3:       return 0;
            default: return $urandom;
        endcase
    endfunction

    // Queue one item and track which elements the stimulus has written so far
    function automatic void queue_item(input logic [MODE_W-1:0] mode, input int r, input int c,
                                       input logic signed [DATA_W-1:0] value);
        in_item_t it;
        it.mode    = mode;
        it.row     = IDX_W'(r);
        it.col     = IDX_W'(c);
        it.element = value;
        if (mode == MODE_WR_LEFT)
            lhs_set[r*MATRIX_DIM + c] = 1'b1;
        else if (mode == MODE_WR_RIGHT)
            rhs_set[r*MATRIX_DIM + c] = 1'b1;
        pending_items.push_back(it);
    endfunction

    function automatic bit row_ready(input int r, input int n);
        for (int k = 0; k < n; k++)
            if (!lhs_set[r*MATRIX_DIM + k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit col_ready(input int c, input int n);
        for (int k = 0; k < n; k++)
            if (!rhs_set[k*MATRIX_DIM + c])
                return 1'b0;
        return 1'b1;
    endfunction

    // Pick a product request that reads no unwritten element; 0 if none found
    function automatic bit queue_request(input int n);
        int rows[$];
        int cols[$];
        int r;
        int c;
        if (n > 0 && $urandom_range(99) < 70)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (row_ready(i, n))
                    rows.push_back(i);
                if (col_ready(i, n))
                    cols.push_back(i);
            end
            if (rows.size() > 0 && cols.size() > 0)
            begin
                queue_item(MODE_PRODUCT, rows[$urandom_range(rows.size()-1)],
                           cols[$urandom_range(cols.size()-1)], rand_element());
                return 1'b1;
            end
        end
        r = $urandom_range(MATRIX_DIM-1);
        c = $urandom_range(MATRIX_DIM-1);
        if (r < n && c < n && !(row_ready(r, n) && col_ready(c, n)))
        begin
            if (n >= MATRIX_DIM)
                return 1'b0;
            // push one index out of range so nothing is read
            if ($urandom_range(1))
                r = $urandom_range(MATRIX_DIM-1, n);
            else
                c = $urandom_range(MATRIX_DIM-1, n);
        end
        queue_item(MODE_PRODUCT, r, c, rand_element());
        return 1'b1;
    endfunction

    task automatic queue_random_phase(input int dim, input int count);
        int n;
        int made;
        int sel;
        int r;
        int c;
        n = (dim > MATRIX_DIM) ? MATRIX_DIM : dim;
        made = 0;
        while (made < count)
        begin
            sel = $urandom_range(99);
            if (n > 0 && (sel < ((n > 16) ? 4 : 35) || (made == 0 && n > 16)))
            begin
                // fill one row and one column, then ask for their product
                r = $urandom_range(n-1);
                c = $urandom_range(n-1);
                for (int k = 0; k < n; k++)
                begin
                    if (!lhs_set[r*MATRIX_DIM + k] || $urandom_range(1))
                    begin
                        queue_item(MODE_WR_LEFT, r, k, rand_element());
                        made++;
                    end
                    if (!rhs_set[k*MATRIX_DIM + c] || $urandom_range(1))
                    begin
                        queue_item(MODE_WR_RIGHT, k, c, rand_element());
                        made++;
                    end
                end
                queue_item(MODE_PRODUCT, r, c, rand_element());
                made++;
            end
            else if (sel < 60)
            begin
                queue_item($urandom_range(1) ? MODE_WR_RIGHT : MODE_WR_LEFT,
                           $urandom_range(MATRIX_DIM-1), $urandom_range(MATRIX_DIM-1),
                           rand_element());
                made++;
            end
            else if (sel < 90)
            begin
                if (queue_request(n))
                    made++;
            end
            else
            begin
                queue_item(MODE_UNUSED, $urandom_range(MATRIX_DIM-1),
                           $urandom_range(MATRIX_DIM-1), rand_element());
            end
        end
    endtask

    // Hold until every item is taken and every product has come back
    task automatic drain();
        do
            @(posedge clk);
        while (pending_items.size() > 0 || start || expected_products.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_dimension(input logic [DIM_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        active_dim = value;
    endtask

    initial
    begin
        for (int i = 0; i < MATRIX_DIM*MATRIX_DIM; i++)
        begin
            lhs_mem[i] = '0;
            rhs_mem[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes in a 2x2 product, out-of-range echoes, ignored mode
        idle_pct = 20;
        write_dimension(7'd2);
        queue_item(MODE_UNUSED, MATRIX_DIM-1, MATRIX_DIM-1, -1);
        queue_item(MODE_WR_LEFT, 0, 0, ELEM_MIN);
        queue_item(MODE_WR_LEFT, 0, 1, ELEM_MAX);
        queue_item(MODE_WR_LEFT, 1, 0, -1);
        queue_item(MODE_WR_LEFT, 1, 1, 0);
        queue_item(MODE_WR_RIGHT, 0, 0, ELEM_MIN);
        queue_item(MODE_WR_RIGHT, 1, 0, ELEM_MAX);
        queue_item(MODE_WR_RIGHT, 0, 1, 1);
        queue_item(MODE_WR_RIGHT, 1, 1, -1);
        queue_item(MODE_PRODUCT, 0, 0, 0);
        queue_item(MODE_PRODUCT, 0, 1, ELEM_MAX);
        queue_item(MODE_PRODUCT, 1, 0, ELEM_MIN);
        queue_item(MODE_PRODUCT, 1, 1, -1);
        // stored beyond the dimension, no effect until it grows
        queue_item(MODE_WR_LEFT, MATRIX_DIM-1, MATRIX_DIM-1, ELEM_MAX);
        queue_item(MODE_WR_RIGHT, MATRIX_DIM-1, MATRIX_DIM-1, ELEM_MIN);
        queue_item(MODE_PRODUCT, MATRIX_DIM-1, 0, 0);
        queue_item(MODE_PRODUCT, 0, MATRIX_DIM-1, 0);
        queue_item(MODE_PRODUCT, MATRIX_DIM-1, MATRIX_DIM-1, 0);
        queue_item(MODE_PRODUCT, 2, 1, 0);
        queue_item(MODE_PRODUCT, 0, 0, 0);
        drain();

        // Empty dot product
        write_dimension(7'd0);
        queue_item(MODE_PRODUCT, 0, 0, 0);
        queue_item(MODE_PRODUCT, MATRIX_DIM-1, MATRIX_DIM-1, 0);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            idle_pct = PHASE_IDLE[(p * 3) / NUM_PHASES];
            write_dimension(DIM_W'(PHASE_DIM[p]));
            queue_random_phase(PHASE_DIM[p], PHASE_ITEMS[p]);
            drain();
        end

        if (error_count == 0 && expected_products.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
